// ----- rtl/core/ofiw_pkg.sv -----
// ofiw_pkg: shared types, constants and helpers for the windowed order flow imbalance unit.
// No dependencies; every other file of the block but ofiw_ram depends on it.

package ofiw_pkg;

    localparam int TS_W      = 48;
    localparam int PX_W      = 32;
    localparam int INC_W     = 34;
    localparam int SUM_W     = 64;
    localparam int WIN_W     = 16;
    localparam int CFG_IDX_W = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WIN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_WIN  = 8'd1;

    localparam logic [WIN_W-1:0] SHORT_WIN_RST = 16'd1000;
    localparam logic [WIN_W-1:0] LONG_WIN_RST  = 16'd5000;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic            mode;
        logic [TS_W-1:0] timestamp_ms;
        logic            quote_present;
        logic [PX_W-1:0] bid_price;
        logic [PX_W-1:0] bid_qty;
        logic [PX_W-1:0] ask_price;
        logic [PX_W-1:0] ask_qty;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] ofi_total;
        logic signed [SUM_W-1:0] ofi_short;
        logic signed [SUM_W-1:0] ofi_long;
        logic                    increment_applied;
        logic                    history_overflow;
    } t_out_item;

    typedef struct packed {
        logic latch;
        logic calc;
        logic trim_read;
        logic trim_pop;
        logic push;
        logic scan_init;
        logic scan_step;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic apply_now;
        logic ring_empty;
        logic trim_expired;
        logic scan_more;
        logic scan_pending;
        logic out_free;
    } t_dp_status;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic [SUM_W:0] sum;
        sum = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (sum[SUM_W] != sum[SUM_W-1]) begin
            return sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return sum[SUM_W-1:0];
    endfunction

endpackage

// ----- rtl/core/ofiw_stream_if.sv -----
// ofiw_stream_if: valid/ready channels for input items and result items.
// Depends on ofiw_pkg for the payload types.

interface ofiw_in_if;
    logic              valid;
    logic              ready;
    ofiw_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ofiw_out_if;
    logic               valid;
    logic               ready;
    ofiw_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/order_flow_imbalance_windowed_unit.sv -----
// order_flow_imbalance_windowed_unit: top level of the best-level order flow imbalance block.
// Depends on ofiw_pkg, ofiw_stream_if, ofiw_ctrl, ofiw_dp and ofiw_ram.
//
// Usage
//   i_in_stream takes one tick per transfer: a book update (mode 0) or a trade tick (mode 1).
//   o_out_stream returns exactly one result per tick: running total, short and long window
//   sums, whether an increment was added, and the sticky ring overflow flag.
//   The window lengths are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must
//   write them only while idle, which the block itself does not enforce.
// Sequence
//   One tick at a time. A book update with a prior quote computes its increment, trims
//   expired entries from the ring head, pushes the new entry and then walks the history
//   ring to form the window sums; other ticks skip the trim and the push. The walk issues
//   one memory read per cycle; the next tick is taken once the result has been loaded.
// Reset
//   Synchronous, active low. Clears the quote state, the total, the ring pointers and the
//   overflow flag, and loads the default windows (1000 ms, 5000 ms). No clearing pass.
// Backpressure
//   The result sits in an output register; the next tick is accepted while it waits, and
//   that tick's result is held back until the waiting one has been taken.

module order_flow_imbalance_windowed_unit #(
    parameter int HISTORY_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ofiw_in_if.sink                        i_in_stream,
    ofiw_out_if.source                     o_out_stream,
    input  logic                           i_cfg_we,
    input  logic [ofiw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ofiw_pkg::WIN_W-1:0]     i_cfg_data
);
    import ofiw_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;
    logic       in_ready;
    logic       out_valid;
    t_out_item  out_payload;

    ofiw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_stream.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ofiw_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_in_stream.payload),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (out_valid),
        .o_out_payload (out_payload),
        .i_out_ready   (o_out_stream.ready)
    );

    assign i_in_stream.ready    = in_ready;
    assign o_out_stream.valid   = out_valid;
    assign o_out_stream.payload = out_payload;

endmodule

// ----- rtl/core/ofiw_ram.sv -----
// ofiw_ram: generic single-write, single-read memory with registered read data.
// No dependencies.

module ofiw_ram #(
    parameter int WIDTH = 82,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ofiw_ctrl.sv -----
// ofiw_ctrl: sequencer for one item: increment, ring trim, push, window scan, result load.
// Depends on ofiw_pkg for the command and status structs.

module ofiw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ofiw_pkg::t_dp_status i_status,
    output ofiw_pkg::t_ctrl_cmd  o_cmd
);
    import ofiw_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_INC       = 8'b0000_0010,
        S_TRIM_RD   = 8'b0000_0100,
        S_TRIM_CHK  = 8'b0000_1000,
        S_PUSH      = 8'b0001_0000,
        S_SCAN_INIT = 8'b0010_0000,
        S_SCAN      = 8'b0100_0000,
        S_DONE      = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_INC;
                end
            end
            S_INC: begin
                o_cmd.calc = 1'b1;
                n_state    = i_status.apply_now ? S_TRIM_RD : S_SCAN_INIT;
            end
            S_TRIM_RD: begin
                if (i_status.ring_empty) begin
                    n_state = S_PUSH;
                end else begin
                    o_cmd.trim_read = 1'b1;
                    n_state         = S_TRIM_CHK;
                end
            end
            S_TRIM_CHK: begin
                // pop the head while it lies outside the long window
                if (i_status.trim_expired) begin
                    o_cmd.trim_pop = 1'b1;
                    n_state        = S_TRIM_RD;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_SCAN_INIT;
            end
            S_SCAN_INIT: begin
                o_cmd.scan_init = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (!i_status.scan_more && !i_status.scan_pending) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/ofiw_dp.sv -----
// ofiw_dp: quote state, increment and running total, history ring, window sums, result register.
// Depends on ofiw_pkg and ofiw_ram.

module ofiw_dp #(
    parameter int HISTORY_DEPTH = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ofiw_pkg::t_in_item                 i_item,
    input  logic                               i_cfg_we,
    input  logic [ofiw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ofiw_pkg::WIN_W-1:0]         i_cfg_data,
    input  ofiw_pkg::t_ctrl_cmd                i_cmd,
    output ofiw_pkg::t_dp_status               o_status,
    output logic                               o_out_valid,
    output ofiw_pkg::t_out_item                o_out_payload,
    input  logic                               i_out_ready
);
    import ofiw_pkg::*;

    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int CW    = $clog2(HISTORY_DEPTH + 1);
    localparam int RAM_W = TS_W + INC_W;
    localparam logic [CW-1:0] DEPTH_CNT  = CW'(HISTORY_DEPTH);
    localparam logic [AW:0]   DEPTH_WIDE = (AW + 1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT  = AW'(HISTORY_DEPTH - 1);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    // registers
    t_in_item                 r_item;
    logic [WIN_W-1:0]         r_short_win;
    logic [WIN_W-1:0]         r_long_win;
    logic                     r_prior_valid;
    logic [PX_W-1:0]          r_prior_bid_price;
    logic [PX_W-1:0]          r_prior_bid_qty;
    logic [PX_W-1:0]          r_prior_ask_price;
    logic [PX_W-1:0]          r_prior_ask_qty;
    logic signed [SUM_W-1:0]  r_total;
    logic signed [INC_W-1:0]  r_inc;
    logic                     r_applied;
    logic [AW-1:0]            r_head;
    logic [CW-1:0]            r_count;
    logic                     r_ovf;
    logic [AW-1:0]            r_rd_ptr;
    logic [CW-1:0]            r_k;
    logic                     r_dv;
    logic signed [SUM_W-1:0]  r_acc_short;
    logic signed [SUM_W-1:0]  r_acc_long;
    logic                     r_out_valid;
    t_out_item                r_out;

    // increment from the new quote against the prior one
    logic                     present;
    logic signed [INC_W-1:0]  bid_part;
    logic signed [INC_W-1:0]  ask_part;
    logic signed [INC_W-1:0]  inc_val;

    assign present = r_item.quote_present;

    always_comb begin
        if (present && (r_item.bid_price > r_prior_bid_price)) begin
            bid_part = {2'b00, r_item.bid_qty};
        end else if (present && (r_item.bid_price < r_prior_bid_price)) begin
            bid_part = -{2'b00, r_prior_bid_qty};
        end else begin
            bid_part = {2'b00, r_item.bid_qty} - {2'b00, r_prior_bid_qty};
        end
        if (present && (r_item.ask_price < r_prior_ask_price)) begin
            ask_part = -{2'b00, r_item.ask_qty};
        end else if (present && (r_item.ask_price > r_prior_ask_price)) begin
            ask_part = {2'b00, r_prior_ask_qty};
        end else begin
            ask_part = {2'b00, r_prior_ask_qty} - {2'b00, r_item.ask_qty};
        end
        inc_val = bid_part + ask_part;
    end

    // ring memory and its ports
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [RAM_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [RAM_W-1:0]    ram_rdata;
    logic [TS_W-1:0]     rd_time;
    logic signed [INC_W-1:0] rd_inc;
    logic signed [SUM_W-1:0] rd_inc_ext;
    logic [AW:0]         tail_sum;
    logic [AW-1:0]       tail_slot;
    logic                ring_full;
    logic                scan_issue;
    logic                hit_short;
    logic                hit_long;

    assign ring_full  = (r_count == DEPTH_CNT);
    assign tail_sum   = {1'b0, r_head} + (AW + 1)'(r_count);
    assign tail_slot  = (tail_sum >= DEPTH_WIDE) ? AW'(tail_sum - DEPTH_WIDE) : tail_sum[AW-1:0];
    assign scan_issue = i_cmd.scan_step && (r_k != r_count);

    assign ram_we    = i_cmd.push;
    // when full the oldest slot is reused
    assign ram_waddr = ring_full ? r_head : tail_slot;
    assign ram_wdata = {r_item.timestamp_ms, r_inc};
    assign ram_re    = i_cmd.trim_read || scan_issue;
    assign ram_raddr = i_cmd.trim_read ? r_head : r_rd_ptr;

    ofiw_ram #(
        .WIDTH (RAM_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_time    = ram_rdata[RAM_W-1:INC_W];
    assign rd_inc     = ram_rdata[INC_W-1:0];
    assign rd_inc_ext = {{(SUM_W-INC_W){rd_inc[INC_W-1]}}, rd_inc};
    assign hit_short  = ({1'b0, rd_time} + (TS_W + 1)'(r_short_win))
                        >= {1'b0, r_item.timestamp_ms};
    assign hit_long   = ({1'b0, rd_time} + (TS_W + 1)'(r_long_win))
                        >= {1'b0, r_item.timestamp_ms};

    // status back to the sequencer
    assign o_status.apply_now    = !r_item.mode && r_prior_valid;
    assign o_status.ring_empty   = (r_count == '0);
    assign o_status.trim_expired = !hit_long;
    assign o_status.scan_more    = (r_k != r_count);
    assign o_status.scan_pending = r_dv;
    assign o_status.out_free     = !r_out_valid || i_out_ready;

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (i_cmd.calc) begin
            r_inc <= inc_val;
        end
        if (i_cmd.scan_init) begin
            r_rd_ptr <= r_head;
        end else if (scan_issue) begin
            r_rd_ptr <= ptr_inc(r_rd_ptr);
        end
        if (i_cmd.scan_init) begin
            r_acc_short <= '0;
            r_acc_long  <= '0;
        end else if (r_dv) begin
            // at most HISTORY_DEPTH entries of 34 bits: below 2**30 entries these sums cannot reach the range ends
            if (hit_short) begin
                r_acc_short <= r_acc_short + rd_inc_ext;
            end
            if (hit_long) begin
                r_acc_long <= r_acc_long + rd_inc_ext;
            end
        end
        if (i_cmd.load_out) begin
            r_out.ofi_total         <= r_total;
            r_out.ofi_short         <= r_acc_short;
            r_out.ofi_long          <= r_acc_long;
            r_out.increment_applied <= r_applied;
            r_out.history_overflow  <= r_ovf;
        end
    end

    // state with reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_win       <= SHORT_WIN_RST;
            r_long_win        <= LONG_WIN_RST;
            r_prior_valid     <= 1'b0;
            r_prior_bid_price <= '0;
            r_prior_bid_qty   <= '0;
            r_prior_ask_price <= '0;
            r_prior_ask_qty   <= '0;
            r_total           <= '0;
            r_applied         <= 1'b0;
            r_head            <= '0;
            r_count           <= '0;
            r_ovf             <= 1'b0;
            r_k               <= '0;
            r_dv              <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SHORT_WIN: r_short_win <= i_cfg_data;
                    CFG_LONG_WIN:  r_long_win  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.calc) begin
                r_applied <= !r_item.mode && r_prior_valid;
                if (!r_item.mode) begin
                    r_prior_valid     <= r_item.quote_present;
                    r_prior_bid_price <= r_item.bid_price;
                    r_prior_bid_qty   <= r_item.bid_qty;
                    r_prior_ask_price <= r_item.ask_price;
                    r_prior_ask_qty   <= r_item.ask_qty;
                end
            end

            if (i_cmd.trim_pop) begin
                r_head  <= ptr_inc(r_head);
                r_count <= r_count - 1'b1;
            end else if (i_cmd.push) begin
                r_total <= sat_add(r_total, {{(SUM_W-INC_W){r_inc[INC_W-1]}}, r_inc});
                if (ring_full) begin
                    r_head <= ptr_inc(r_head);
                    r_ovf  <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end

            if (i_cmd.scan_init) begin
                r_k <= '0;
            end else if (scan_issue) begin
                r_k <= r_k + 1'b1;
            end
            r_dv <= scan_issue;

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_payload = r_out;

endmodule

// ----- rtl/core/ofiw_checker.sv -----
// ofiw_checker: port-level assertions for the order flow imbalance unit, bound to the top.
// Depends on ofiw_pkg and order_flow_imbalance_windowed_unit.

module ofiw_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input ofiw_pkg::t_out_item i_out_payload
);
    import ofiw_pkg::*;

    logic                    in_xfer;
    logic                    out_xfer;
    logic [1:0]              r_outstanding;
    logic                    r_seen_ovf;
    logic                    r_have_prev;
    logic signed [SUM_W-1:0] r_prev_total;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
            r_seen_ovf    <= 1'b0;
            r_have_prev   <= 1'b0;
            r_prev_total  <= '0;
        end else begin
            r_outstanding <= r_outstanding + {1'b0, in_xfer} - {1'b0, out_xfer};
            if (out_xfer) begin
                r_have_prev  <= 1'b1;
                r_prev_total <= i_out_payload.ofi_total;
                if (i_out_payload.history_overflow) begin
                    r_seen_ovf <= 1'b1;
                end
            end
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("stalled result changed");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen_ovf |-> i_out_payload.history_overflow)
        else $error("overflow flag dropped");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> r_outstanding < 2'd2)
        else $error("tick taken while two results are owed");

    a_total_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_have_prev && !i_out_payload.increment_applied
        |-> i_out_payload.ofi_total == r_prev_total)
        else $error("total moved without an increment");

endmodule

bind order_flow_imbalance_windowed_unit ofiw_checker u_ofiw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_stream.valid),
    .i_in_ready    (i_in_stream.ready),
    .i_out_valid   (o_out_stream.valid),
    .i_out_ready   (o_out_stream.ready),
    .i_out_payload (o_out_stream.payload)
);
